// ===== hdl/ubx_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// ubx_rx_pkg
// Shared types and constants of the binary frame receiver: sync bytes, the
// frame phase encoding, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ubx_rx_pkg;

    // Sync pair that opens every frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECT_CLASS  = 2'd0;
    localparam logic [1:0] CFG_EXPECT_MSG_ID = 2'd1;
    localparam logic [1:0] CFG_KEEP_LIMIT    = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  RST_EXPECT_CLASS  = 8'd10;
    localparam logic [7:0]  RST_EXPECT_MSG_ID = 8'd4;
    localparam logic [15:0] RST_KEEP_LIMIT    = 16'd220;

    // Frame parse phase, one-hot.
    typedef enum logic [8:0] {
        PH_HUNT1 = 9'b000000001,
        PH_HUNT2 = 9'b000000010,
        PH_CLASS = 9'b000000100,
        PH_ID    = 9'b000001000,
        PH_LEN_L = 9'b000010000,
        PH_LEN_H = 9'b000100000,
        PH_PAY   = 9'b001000000,
        PH_CK_A  = 9'b010000000,
        PH_CK_B  = 9'b100000000
    } phase_t;

endpackage : ubx_rx_pkg

`default_nettype wire

// ===== hdl/ubx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Byte-stream parser for sync-framed binary messages with a Fletcher-8 check.
// An accepted byte's result item is registered; it shows in the next cycle.
// Throughput: one byte per cycle unless stalled; the parse state register
// updates once per accepted byte; the result register frees itself when taken.
// Reset: synchronous, active low; the parser returns to sync hunting, the
// registers take their defaults and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_receiver
    import ubx_rx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,

    // Input byte channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_restart,

    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic [15:0]      m_payload_index,
    output logic             m_frame_match,
    output logic             m_frame_reject,
    output logic [15:0]      m_frame_length
);

    // Configuration registers.
    logic [7:0]  expect_class_reg;
    logic [7:0]  expect_msg_id_reg;
    logic [15:0] keep_limit_reg;

    // Parse state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  got_class_reg, got_class_next;
    logic [7:0]  got_msg_id_reg, got_msg_id_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  first_check_reg, first_check_next;
    logic [15:0] payload_len_reg, payload_len_next;
    logic [15:0] payload_pos_reg, payload_pos_next;

    // Result register.
    logic        m_valid_reg;
    logic        pv_reg, pv_next;
    logic [7:0]  pb_reg, pb_next;
    logic [15:0] pi_reg, pi_next;
    logic        fm_reg, fm_next;
    logic        fr_reg, fr_next;
    logic [15:0] fl_reg, fl_next;

    // Working values.
    phase_t      cur_phase;
    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] pos_inc;
    logic [15:0] full_len;
    logic        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_class_reg  <= RST_EXPECT_CLASS;
            expect_msg_id_reg <= RST_EXPECT_MSG_ID;
            keep_limit_reg    <= RST_KEEP_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECT_CLASS:  expect_class_reg  <= cfg_wdata[7:0];
                CFG_EXPECT_MSG_ID: expect_msg_id_reg <= cfg_wdata[7:0];
                CFG_KEEP_LIMIT:    keep_limit_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Fletcher sums and the payload position step.
    assign add_a    = sum_a_reg + s_rx_byte;
    assign add_b    = sum_b_reg + add_a;
    assign pos_inc  = payload_pos_reg + 16'd1;
    assign full_len = {s_rx_byte, payload_len_reg[7:0]};

    // A restart drops the partial frame, so the byte is seen in the hunt phase.
    assign cur_phase = s_restart ? PH_HUNT1 : phase_reg;

    // Next parse state and result for the byte on the input.
    always_comb begin
        phase_next       = cur_phase;
        got_class_next   = got_class_reg;
        got_msg_id_next  = got_msg_id_reg;
        sum_a_next       = s_restart ? 8'd0 : sum_a_reg;
        sum_b_next       = s_restart ? 8'd0 : sum_b_reg;
        first_check_next = first_check_reg;
        payload_len_next = payload_len_reg;
        payload_pos_next = s_restart ? 16'd0 : payload_pos_reg;
        pv_next          = 1'b0;
        pb_next          = 8'd0;
        pi_next          = 16'd0;
        fm_next          = 1'b0;
        fr_next          = 1'b0;
        fl_next          = 16'd0;

        unique case (cur_phase)
            PH_HUNT1: begin
                phase_next = (s_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HUNT2: begin
                if (s_rx_byte == SYNC_SECOND) begin
                    phase_next = PH_CLASS;
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                end else if (s_rx_byte != SYNC_FIRST) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                got_class_next = s_rx_byte;
                sum_a_next     = add_a;
                sum_b_next     = add_b;
                phase_next     = PH_ID;
            end
            PH_ID: begin
                got_msg_id_next = s_rx_byte;
                sum_a_next      = add_a;
                sum_b_next      = add_b;
                phase_next      = PH_LEN_L;
            end
            PH_LEN_L: begin
                payload_len_next = {8'd0, s_rx_byte};
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                phase_next       = PH_LEN_H;
            end
            PH_LEN_H: begin
                payload_len_next = full_len;
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                payload_pos_next = 16'd0;
                phase_next       = (full_len == 16'd0) ? PH_CK_A : PH_PAY;
            end
            PH_PAY: begin
                // Bytes past the keep limit still enter the checksum.
                if (payload_pos_reg < keep_limit_reg) begin
                    pv_next = 1'b1;
                    pb_next = s_rx_byte;
                    pi_next = payload_pos_reg;
                end
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                payload_pos_next = pos_inc;
                if (pos_inc >= payload_len_reg) begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A: begin
                first_check_next = s_rx_byte;
                phase_next       = PH_CK_B;
            end
            PH_CK_B: begin
                if (first_check_reg == sum_a_reg && s_rx_byte == sum_b_reg &&
                    got_class_reg == expect_class_reg &&
                    got_msg_id_reg == expect_msg_id_reg) begin
                    fm_next = 1'b1;
                    fl_next = (payload_len_reg < keep_limit_reg) ?
                              payload_len_reg : keep_limit_reg;
                end else begin
                    fr_next = 1'b1;
                end
                phase_next = PH_HUNT1;
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // Parse state update on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT1;
            got_class_reg   <= 8'd0;
            got_msg_id_reg  <= 8'd0;
            sum_a_reg       <= 8'd0;
            sum_b_reg       <= 8'd0;
            first_check_reg <= 8'd0;
            payload_len_reg <= 16'd0;
            payload_pos_reg <= 16'd0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            got_class_reg   <= got_class_next;
            got_msg_id_reg  <= got_msg_id_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            first_check_reg <= first_check_next;
            payload_len_reg <= payload_len_next;
            payload_pos_reg <= payload_pos_next;
        end
    end

    // Result register; it holds while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pv_reg <= pv_next;
            pb_reg <= pb_next;
            pi_reg <= pi_next;
            fm_reg <= fm_next;
            fr_reg <= fr_next;
            fl_reg <= fl_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_valid = pv_reg;
    assign m_payload_byte  = pb_reg;
    assign m_payload_index = pi_reg;
    assign m_frame_match   = fm_reg;
    assign m_frame_reject  = fr_reg;
    assign m_frame_length  = fl_reg;

    // A result never carries a payload byte and a frame verdict together.
    a_payload_or_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload_valid && (m_frame_match || m_frame_reject)))
        else $error("payload byte and frame verdict in one result");

    // Match and reject exclude each other.
    a_one_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_match && m_frame_reject))
        else $error("frame both matched and rejected");

    // A verdict always sends the parser back to sync hunting.
    a_verdict_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (fm_next || fr_next) |=> phase_reg == PH_HUNT1)
        else $error("parser not hunting after a frame verdict");

    // A frame length is reported only with a match.
    a_length_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_match |-> m_frame_length == 16'd0)
        else $error("frame length without a match");

endmodule : ubx_frame_receiver

`default_nettype wire
